// ===== rtl/s2s_pkg.sv =====
// shared types and constants for the symmetric 2x2 solver
// no dependencies; used by s2s_div and symmetric_2x2_solver
package s2s_pkg;

	localparam int DEN_W     = 64;   // determinant / remainder width
	localparam int Q_W       = 32;   // quotient bits per lane
	localparam int DIV_STEPS = Q_W;  // one quotient bit per stage

	// per-word status that travels beside the divider lanes
	typedef struct packed {
		logic det_err;
		logic neg1;
		logic neg2;
		logic presat1;
		logic presat2;
	} side_t;

endpackage

// ===== rtl/s2s_div.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage
// depends on s2s_pkg
module s2s_div import s2s_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DEN_W-1:0] den,
	input  logic [DEN_W-1:0] rem1,
	input  logic [DEN_W-1:0] rem2,
	input  logic [Q_W-1:0]   low1,
	input  logic [Q_W-1:0]   low2,
	input  side_t            side_in,
	output logic             out_valid,
	output logic [Q_W-1:0]   q1,
	output logic [Q_W-1:0]   q2,
	output side_t            side_out
);

	logic             valid_s [1:DIV_STEPS];
	logic [DEN_W-1:0] den_s   [1:DIV_STEPS];
	logic [DEN_W-1:0] rem1_s  [1:DIV_STEPS];
	logic [DEN_W-1:0] rem2_s  [1:DIV_STEPS];
	logic [Q_W-1:0]   low1_s  [1:DIV_STEPS];
	logic [Q_W-1:0]   low2_s  [1:DIV_STEPS];
	side_t            side_s  [1:DIV_STEPS];

	// next remainder and shifted quotient of each step
	logic [DEN_W-1:0] rem1_n  [0:DIV_STEPS-1];
	logic [DEN_W-1:0] rem2_n  [0:DIV_STEPS-1];
	logic [Q_W-1:0]   low1_n  [0:DIV_STEPS-1];
	logic [Q_W-1:0]   low2_n  [0:DIV_STEPS-1];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [DEN_W-1:0] den_k, rem1_k, rem2_k;
		logic [Q_W-1:0]   low1_k, low2_k;
		logic [DEN_W:0]   t1, t2, d1, d2;
		logic             ge1, ge2;

		if (k == 0) begin : g_head
			assign den_k  = den;
			assign rem1_k = rem1;
			assign rem2_k = rem2;
			assign low1_k = low1;
			assign low2_k = low2;
		end else begin : g_body
			assign den_k  = den_s[k];
			assign rem1_k = rem1_s[k];
			assign rem2_k = rem2_s[k];
			assign low1_k = low1_s[k];
			assign low2_k = low2_s[k];
		end

		// shift in next dividend bit, subtract when it fits
		assign t1  = {rem1_k, low1_k[Q_W-1]};
		assign t2  = {rem2_k, low2_k[Q_W-1]};
		assign ge1 = t1 >= {1'b0, den_k};
		assign ge2 = t2 >= {1'b0, den_k};
		assign d1  = ge1 ? t1 - {1'b0, den_k} : t1;
		assign d2  = ge2 ? t2 - {1'b0, den_k} : t2;

		assign rem1_n[k] = d1[DEN_W-1:0];
		assign rem2_n[k] = d2[DEN_W-1:0];
		assign low1_n[k] = {low1_k[Q_W-2:0], ge1};
		assign low2_n[k] = {low2_k[Q_W-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DIV_STEPS; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s[1] <= in_valid;
			for (int k = 2; k <= DIV_STEPS; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[1]  <= den;
			side_s[1] <= side_in;
			for (int k = 2; k <= DIV_STEPS; k++) begin
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
			for (int k = 1; k <= DIV_STEPS; k++) begin
				rem1_s[k] <= rem1_n[k-1];
				rem2_s[k] <= rem2_n[k-1];
				low1_s[k] <= low1_n[k-1];
				low2_s[k] <= low2_n[k-1];
			end
		end
	end

	// after all steps the low registers hold the quotients
	assign out_valid = valid_s[DIV_STEPS];
	assign q1        = low1_s[DIV_STEPS];
	assign q2        = low2_s[DIV_STEPS];
	assign side_out  = side_s[DIV_STEPS];

endmodule

// ===== rtl/symmetric_2x2_solver.sv =====
// symmetric 2x2 solver top level: cramer's rule in signed fixed point
// depends on s2s_pkg and s2s_div
// pipeline: 37 register stages (4 front stages, 32 divider stages, 1 output register);
// a word accepted at the input passes through them in that order to the output
// throughput: one word per cycle; the whole pipe advances together and holds on output stall
// reset: arst_n clears all valid bits asynchronously; data registers are not reset
module symmetric_2x2_solver import s2s_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// diag_a, diag_b, off_diag, rhs_first, rhs_second (32 bits each, lowest first)
	input  logic [159:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// sol_first, sol_second (32 bits each, lowest first)
	output logic [63:0]  m_axis_tdata,
	// det_error, overflow (lowest first)
	output logic [1:0]   m_axis_tuser
);

	localparam int NW = DEN_W + FRAC_BITS;  // width of magnitude scaled by 2^FRAC_BITS
	localparam int HW = NW - Q_W;           // high part checked before dividing

	// whole pipe moves when the output register is free or drained
	logic adv;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	logic signed [31:0] a_in, b_in, c_in, y1_in, y2_in;
	assign a_in  = s_axis_tdata[31:0];
	assign b_in  = s_axis_tdata[63:32];
	assign c_in  = s_axis_tdata[95:64];
	assign y1_in = s_axis_tdata[127:96];
	assign y2_in = s_axis_tdata[159:128];

	// stage 1: the six exact products
	logic               v_s1;
	logic signed [63:0] pab_s1, pcc_s1, pby1_s1, pcy2_s1, pay2_s1, pcy1_s1;

	// stage 2: determinant and both numerators
	logic               v_s2;
	logic signed [63:0] det_s2;
	logic signed [64:0] n1_s2, n2_s2;

	// stage 3: sign split into magnitudes and determinant error flag
	logic               v_s3;
	logic [DEN_W-1:0]   den_s3, mag1_s3, mag2_s3;
	logic               neg1_s3, neg2_s3, err_s3;

	// stage 4: presaturation check and divider seed
	logic               v_s4;
	logic [DEN_W-1:0]   den_s4, rem1_s4, rem2_s4;
	logic [Q_W-1:0]     low1_s4, low2_s4;
	side_t              side_s4;

	logic [64:0] mneg1, mneg2;
	logic [NW-1:0] sh1, sh2;
	logic [DEN_W-1:0] hi1, hi2;

	assign mneg1 = n1_s2[64] ? (~n1_s2 + 65'd1) : n1_s2;
	assign mneg2 = n2_s2[64] ? (~n2_s2 + 65'd1) : n2_s2;

	assign sh1 = {mag1_s3, {FRAC_BITS{1'b0}}};
	assign sh2 = {mag2_s3, {FRAC_BITS{1'b0}}};
	assign hi1 = {{(DEN_W-HW){1'b0}}, sh1[NW-1:Q_W]};
	assign hi2 = {{(DEN_W-HW){1'b0}}, sh2[NW-1:Q_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pab_s1  <= a_in * b_in;
			pcc_s1  <= c_in * c_in;
			pby1_s1 <= b_in * y1_in;
			pcy2_s1 <= c_in * y2_in;
			pay2_s1 <= a_in * y2_in;
			pcy1_s1 <= c_in * y1_in;

			det_s2 <= pab_s1 - pcc_s1;
			n1_s2  <= {pby1_s1[63], pby1_s1} - {pcy2_s1[63], pcy2_s1};
			n2_s2  <= {pay2_s1[63], pay2_s1} - {pcy1_s1[63], pcy1_s1};

			err_s3  <= det_s2 <= 64'sd0;
			den_s3  <= det_s2;
			neg1_s3 <= n1_s2[64];
			neg2_s3 <= n2_s2[64];
			mag1_s3 <= mneg1[DEN_W-1:0];
			mag2_s3 <= mneg2[DEN_W-1:0];

			// quotient of 2^32 or more always saturates; the remainder is seeded in either case
			den_s4          <= den_s3;
			side_s4.det_err <= err_s3;
			side_s4.neg1    <= neg1_s3;
			side_s4.neg2    <= neg2_s3;
			side_s4.presat1 <= hi1 >= den_s3;
			side_s4.presat2 <= hi2 >= den_s3;
			rem1_s4         <= hi1;
			rem2_s4         <= hi2;
			low1_s4         <= sh1[Q_W-1:0];
			low2_s4         <= sh2[Q_W-1:0];
		end
	end

	// long division, one bit per stage
	logic           dv;
	logic [Q_W-1:0] q1, q2;
	side_t          dside;

	s2s_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s4),
		.den       (den_s4),
		.rem1      (rem1_s4),
		.rem2      (rem2_s4),
		.low1      (low1_s4),
		.low2      (low2_s4),
		.side_in   (side_s4),
		.out_valid (dv),
		.q1        (q1),
		.q2        (q2),
		.side_out  (dside)
	);

	// final sign, saturation and error select
	localparam logic [Q_W-1:0] POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] NEG_MIN = {1'b1, {(Q_W-1){1'b0}}};

	logic           sat1, sat2;
	logic [Q_W-1:0] x1, x2;

	always_comb begin
		sat1 = dside.presat1 || (dside.neg1 ? (q1 > NEG_MIN) : q1[Q_W-1]);
		sat2 = dside.presat2 || (dside.neg2 ? (q2 > NEG_MIN) : q2[Q_W-1]);
		if (sat1) begin
			x1 = dside.neg1 ? NEG_MIN : POS_MAX;
		end else begin
			x1 = dside.neg1 ? (~q1 + 32'd1) : q1;
		end
		if (sat2) begin
			x2 = dside.neg2 ? NEG_MIN : POS_MAX;
		end else begin
			x2 = dside.neg2 ? (~q2 + 32'd1) : q2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dside.det_err) begin
				m_axis_tdata <= '0;
				m_axis_tuser <= 2'b01;
			end else begin
				m_axis_tdata <= {x2, x1};
				m_axis_tuser <= {sat1 || sat2, 1'b0};
			end
		end
	end

	// error words carry zero solutions and no overflow
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 64'd0 && !m_axis_tuser[1])
		else $error("error word with nonzero payload");

	// overflow means at least one component sits at a rail
	a_ovf_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			m_axis_tdata[31:0] == POS_MAX || m_axis_tdata[31:0] == NEG_MIN ||
			m_axis_tdata[63:32] == POS_MAX || m_axis_tdata[63:32] == NEG_MIN)
		else $error("overflow flagged without saturated component");

	// a word leaving the divider reaches the output on the next advance
	a_div_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && dv |=> m_axis_tvalid)
		else $error("divider word lost");

endmodule

// ===== tb/symmetric_2x2_solver_tb.sv =====
// testbench for symmetric_2x2_solver: streams 2x2 symmetric systems through the block
// and compares every solution word with an in-bench cramer's-rule predictor; needs s2s_pkg
module symmetric_2x2_solver_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import s2s_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = 37;

	typedef struct packed {
		logic signed [31:0] rhs_second;
		logic signed [31:0] rhs_first;
		logic signed [31:0] off_diag;
		logic signed [31:0] diag_b;
		logic signed [31:0] diag_a;
	} system_t;

	typedef struct packed {
		logic               overflow;
		logic               det_error;
		logic signed [31:0] sol_second;
		logic signed [31:0] sol_first;
	} solution_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [63:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	system_t   pending_systems[$];
	solution_t expected_solutions[$];
	int        mismatches = 0;
	int        solved = 0;
	int        n_det_err = 0;
	int        n_ovf = 0;
	int        src_idle_pct = 0;
	int        sink_stall_pct = 0;
	bit        sink_hold = 0;     // long receiver hold-off
	bit        src_pause = 0;     // sender waits for the pipe to drain

	always #1 clk = ~clk;

	symmetric_2x2_solver #(.FRAC_BITS(FRAC)) u_top (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
	);

	// quotient n/d rescaled by FRAC bits, truncated toward zero and saturated
	function automatic logic [31:0] scaled_quotient(input logic signed [63:0] n,
			input logic signed [63:0] d, inout logic sat);
		logic              neg;
		logic [127:0]      mag;
		logic [127:0]      q;
		logic [127:0]      lim;
		neg = n < 0;
		mag = neg ? 128'(-n) : 128'(n);
		mag = mag & {64'd0, {64{1'b1}}};
		q = (mag << FRAC) / 128'(d);
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (q > lim) begin
			sat = 1;
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return neg ? 32'(-q) : 32'(q);
	endfunction

	function automatic solution_t cramer_solve(input system_t s);
		solution_t          r;
		logic signed [63:0] det;
		logic               sat;
		r = '0;
		sat = 0;
		det = 64'(s.diag_a) * 64'(s.diag_b) - 64'(s.off_diag) * 64'(s.off_diag);
		if (det <= 0) begin
			r.det_error = 1;
			return r;
		end
		r.sol_first = scaled_quotient(64'(s.diag_b) * 64'(s.rhs_first)
			- 64'(s.off_diag) * 64'(s.rhs_second), det, sat);
		r.sol_second = scaled_quotient(64'(s.diag_a) * 64'(s.rhs_second)
			- 64'(s.off_diag) * 64'(s.rhs_first), det, sat);
		r.overflow = sat;
		return r;
	endfunction

	// driver: presents the next pending system, honoring random idle and pauses, and drives receiver ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_systems.size() > 0 && !src_pause
						&& $urandom_range(99) >= src_idle_pct) begin
					s_axis_tdata <= pending_systems[0];
					expected_solutions.push_back(cramer_solve(pending_systems[0]));
					void'(pending_systems.pop_front());
					s_axis_tvalid <= 1;
				end else begin
					s_axis_tvalid <= 0;
				end
			end
			m_axis_tready <= !sink_hold && $urandom_range(99) >= sink_stall_pct;
		end
	end

	// monitor: every accepted result word against the oldest expectation
	always @(posedge clk) begin
		solution_t got;
		solution_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata};
			solved++;
			if (expected_solutions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h", got);
			end else begin
				want = expected_solutions.pop_front();
				n_det_err += want.det_error;
				n_ovf += want.overflow;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: x1 %h/%h x2 %h/%h err %b/%b ovf %b/%b (exp/act)",
							want.sol_first, got.sol_first, want.sol_second, got.sol_second,
							want.det_error, got.det_error, want.overflow, got.overflow);
				end
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(8 << FRAC)) - (4 << FRAC));
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
		endcase
	endfunction

	// mostly positive diagonals with a bounded off-diagonal (determinant not always positive), rest raw noise
	function automatic system_t rand_system();
		system_t s;
		s.diag_a = rand_word();
		s.diag_b = rand_word();
		s.off_diag = rand_word();
		s.rhs_first = rand_word();
		s.rhs_second = rand_word();
		if ($urandom_range(99) < 70) begin
			s.diag_a = 32'($urandom_range(1 << 22) + 1);
			s.diag_b = 32'($urandom_range(1 << 22) + 1);
			s.off_diag = 32'($signed($urandom_range(1 << 20)) - (1 << 19));
		end
		return s;
	endfunction

	task automatic add_system(input logic [31:0] a, b, c, y1, y2);
		pending_systems.push_back({y2, y1, c, b, a});
	endtask

	task automatic wait_drained();
		while (pending_systems.size() > 0 || s_axis_tvalid || expected_solutions.size() > 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int n, input int idle, input int stall);
		src_idle_pct = idle;
		sink_stall_pct = stall;
		repeat (n) pending_systems.push_back(rand_system());
		wait_drained();
	endtask

	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
	localparam logic [31:0] MINV = 32'h8000_0000;

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		// directed: identity, singular, negative det, saturation, extremes
		add_system(ONE, ONE, 0, ONE, MINV);
		add_system(ONE, ONE, 0, MAXV, MAXV);
		add_system(ONE, ONE, ONE, ONE, ONE);          // singular
		add_system(0, 0, 0, 0, 0);
		add_system(ONE, 0 - ONE, 0, ONE, ONE);        // negative det
		add_system(32'd1, 32'd1, 0, MAXV, MINV);      // tiny det, saturate both ways
		add_system(MAXV, MAXV, MINV, ONE, ONE);       // c*c dominates
		add_system(MINV, MINV, 0, MAXV, MINV);        // two negatives, positive det
		add_system(MINV, MINV, MAXV, MINV, MINV);
		add_system(MAXV, MAXV, 0, MAXV, MINV);
		add_system(2 * ONE, 3 * ONE, ONE, 5 * ONE, 0 - ONE);
		add_system(ONE, ONE, 32'hFFFF_0001, MINV, MAXV);
		add_system(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1);
		add_system(32'h5555_5555, 32'hAAAA_AAAA, 0, 32'h5555_5555, 32'hAAAA_AAAA);
		add_system(32'h0000_0003, 32'h0000_0007, 32'h0000_0002, 32'h0000_0001, 32'hFFFF_FFFF);
		wait_drained();

		run_phase(400, 0, 0);
		run_phase(250, 85, 0);
		run_phase(250, 0, 85);
		run_phase(250, 15, 15);

		// receiver holds off long while the sender keeps offering words
		repeat (100) pending_systems.push_back(rand_system());
		src_idle_pct = 0;
		sink_hold = 1;
		repeat (200) @(posedge clk);
		sink_hold = 0;
		wait_drained();

		// sender pauses with words pending until all results are in
		repeat (300) pending_systems.push_back(rand_system());
		sink_stall_pct = 30;
		repeat (50) @(posedge clk);
		src_pause = 1;
		while (s_axis_tvalid || expected_solutions.size() > 0) @(posedge clk);
		src_pause = 0;
		wait_drained();

		run_phase(300, 30, 30);
		repeat (LATENCY + 10) @(posedge clk);

		$display("solved %0d systems: %0d with non-positive determinant, %0d saturated",
			solved, n_det_err, n_ovf);
		$display("idle phases: none, sender, receiver, both, long hold-off, drain pause");
		if (mismatches == 0 && expected_solutions.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
